[rtl/core/rtcbm_pkg.sv]
package rtcbm_pkg;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [0:0] REG_HALF_PERIOD = 1'b0;

  localparam logic [7:0] HALF_PERIOD_RESET = 8'd1;

  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_SEND_LOW  = 3'd1;
  localparam logic [2:0] PH_SEND_HIGH = 3'd2;
  localparam logic [2:0] PH_RECV_LOW  = 3'd3;
  localparam logic [2:0] PH_RECV_HIGH = 3'd4;

  localparam logic [4:0] READ_BITS  = 5'd8;
  localparam logic [4:0] WRITE_BITS = 5'd16;

  typedef struct packed {
    logic [2:0]  phase;
    logic [4:0]  bit_index;
    logic [15:0] shift_word;
    logic [7:0]  read_acc;
    logic [7:0]  hold_count;
    logic        mode_read;
    logic        mode_bcd;
  } state_t;

  typedef struct packed {
    logic       start_req;
    logic       is_read;
    logic [7:0] reg_command;
    logic [7:0] write_value;
    logic       bcd;
    logic       io_pin;
  } item_t;

  typedef struct packed {
    logic       chip_enable;
    logic       serial_clock;
    logic       data_out;
    logic       data_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_value;
  } result_t;

  // Division by ten through a reciprocal multiply, exact for all byte values.
  function automatic logic [7:0] bin_to_bcd(input logic [7:0] v);
    logic [15:0] prod;
    logic [4:0]  q;
    logic [7:0]  rem;
    prod = {8'd0, v} * 16'd205;
    q    = prod[15:11];
    rem  = v - ({3'd0, q} * 8'd10);
    return {q[3:0], rem[3:0]};
  endfunction

  function automatic logic [7:0] bcd_to_bin(input logic [7:0] v);
    logic [7:0] hi;
    hi = {4'd0, v[7:4]} * 8'd10;
    return hi + {4'd0, v[3:0]};
  endfunction

endpackage

[rtl/core/rtcbm_step.sv]
module rtcbm_step (
  input  rtcbm_pkg::state_t  st,
  input  rtcbm_pkg::item_t   item,
  input  logic [7:0]         half_period,
  output rtcbm_pkg::state_t  st_nxt,
  output rtcbm_pkg::result_t res
);

  logic [7:0] h;
  logic [8:0] hold_inc;
  logic [4:0] bit_inc;
  logic       active;
  logic       done;
  logic [7:0] rval;
  logic [7:0] acc_new;
  logic [7:0] wdata;

  always_comb begin
    h        = (half_period == 8'd0) ? 8'd1 : half_period;
    hold_inc = {1'b0, st.hold_count} + 9'd1;
    bit_inc  = st.bit_index + 5'd1;
    active   = (st.phase == rtcbm_pkg::PH_SEND_LOW) || (st.phase == rtcbm_pkg::PH_SEND_HIGH) ||
               (st.phase == rtcbm_pkg::PH_RECV_LOW) || (st.phase == rtcbm_pkg::PH_RECV_HIGH);
    acc_new  = st.read_acc | ({7'd0, item.io_pin} << st.bit_index[2:0]);
    wdata    = item.bcd ? rtcbm_pkg::bin_to_bcd(item.write_value) : item.write_value;
    done     = 1'b0;
    rval     = 8'd0;
    st_nxt   = st;

    if (!active) begin
      st_nxt.phase = rtcbm_pkg::PH_IDLE;
      if (item.start_req) begin
        st_nxt.mode_read  = item.is_read;
        st_nxt.mode_bcd   = item.bcd;
        st_nxt.shift_word = item.is_read ? {8'd0, item.reg_command | 8'h01}
                                         : {wdata, item.reg_command};
        st_nxt.bit_index  = 5'd0;
        st_nxt.read_acc   = 8'd0;
        st_nxt.hold_count = 8'd0;
        st_nxt.phase      = rtcbm_pkg::PH_SEND_LOW;
      end
    end else if (hold_inc < {1'b0, h}) begin
      st_nxt.hold_count = hold_inc[7:0];
    end else begin
      st_nxt.hold_count = 8'd0;
      unique case (st.phase)
        rtcbm_pkg::PH_SEND_LOW: begin
          st_nxt.phase = rtcbm_pkg::PH_SEND_HIGH;
        end
        rtcbm_pkg::PH_SEND_HIGH: begin
          st_nxt.bit_index = bit_inc;
          if (st.mode_read) begin
            if (bit_inc >= rtcbm_pkg::READ_BITS) begin
              st_nxt.bit_index = 5'd0;
              st_nxt.phase     = rtcbm_pkg::PH_RECV_LOW;
            end else begin
              st_nxt.phase = rtcbm_pkg::PH_SEND_LOW;
            end
          end else if (bit_inc >= rtcbm_pkg::WRITE_BITS) begin
            st_nxt.bit_index = 5'd0;
            st_nxt.phase     = rtcbm_pkg::PH_IDLE;
            done             = 1'b1;
          end else begin
            st_nxt.phase = rtcbm_pkg::PH_SEND_LOW;
          end
        end
        rtcbm_pkg::PH_RECV_LOW: begin
          st_nxt.read_acc  = acc_new;
          st_nxt.bit_index = bit_inc;
          if (bit_inc >= rtcbm_pkg::READ_BITS) begin
            st_nxt.bit_index = 5'd0;
            st_nxt.phase     = rtcbm_pkg::PH_IDLE;
            done             = 1'b1;
            rval             = st.mode_bcd ? rtcbm_pkg::bcd_to_bin(acc_new) : acc_new;
          end else begin
            st_nxt.phase = rtcbm_pkg::PH_RECV_HIGH;
          end
        end
        default: begin
          st_nxt.phase = rtcbm_pkg::PH_RECV_LOW;
        end
      endcase
    end

    res.chip_enable  = 1'b0;
    res.serial_clock = 1'b0;
    res.data_out     = 1'b0;
    res.data_drive   = 1'b1;
    case (st_nxt.phase) inside
      rtcbm_pkg::PH_SEND_LOW, rtcbm_pkg::PH_SEND_HIGH: begin
        res.chip_enable  = 1'b1;
        res.serial_clock = (st_nxt.phase == rtcbm_pkg::PH_SEND_HIGH);
        res.data_out     = st_nxt.shift_word[st_nxt.bit_index[3:0]];
      end
      rtcbm_pkg::PH_RECV_LOW, rtcbm_pkg::PH_RECV_HIGH: begin
        res.chip_enable  = 1'b1;
        res.serial_clock = (st_nxt.phase == rtcbm_pkg::PH_RECV_HIGH);
        res.data_drive   = 1'b0;
      end
      default: begin
      end
    endcase
    res.busy_res   = (st_nxt.phase != rtcbm_pkg::PH_IDLE);
    res.done_res   = done;
    res.read_value = rval;
  end

endmodule

[rtl/core/three_wire_rtc_byte_master.sv]
// Channel    Direction  Handshake            Contents
// in_*       input      in_valid/in_ready    one tick: request fields and sampled data pin
// out_*      output     out_valid/out_ready  pin levels, busy, done and read byte
// APB        input      psel/penable/pready  half_period_ticks at byte address 0
//
// One word is accepted per cycle while the output is not stalled.
// The word is held in the input register, then the transfer state
// machine steps once and the result register is loaded in the same cycle.
// Reset idles the transfer machine, empties both registers and sets the
// half period to one. A stalled output holds the input register, which
// then drops in_ready until the result is taken.
module three_wire_rtc_byte_master (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_start_req,
  input  logic                               in_is_read,
  input  logic [7:0]                         in_reg_command,
  input  logic [7:0]                         in_write_value,
  input  logic                               in_bcd,
  input  logic                               in_io_pin,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_chip_enable,
  output logic                               out_serial_clock,
  output logic                               out_data_out,
  output logic                               out_data_drive,
  output logic                               out_busy_res,
  output logic                               out_done_res,
  output logic [7:0]                         out_read_value,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rtcbm_pkg::CfgAddrW-1:0]     paddr,
  input  logic [rtcbm_pkg::CfgDataW-1:0]     pwdata,
  output logic [rtcbm_pkg::CfgDataW-1:0]     prdata,
  output logic                               pready
);

  logic [7:0]         half_r;
  rtcbm_pkg::state_t  st_r;
  rtcbm_pkg::state_t  st_nxt;
  logic               s1_valid_r;
  rtcbm_pkg::item_t   s1_item_r;
  logic               out_valid_r;
  rtcbm_pkg::result_t out_res_r;
  rtcbm_pkg::result_t res_nxt;
  logic               out_free;
  logic               advance;
  logic               cfg_write;
  logic               reg_hit;

  assign out_free  = !out_valid_r || out_ready;
  assign advance   = s1_valid_r && out_free;
  assign in_ready  = !s1_valid_r || advance;
  assign reg_hit   = (paddr[2] == rtcbm_pkg::REG_HALF_PERIOD);
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = reg_hit ? {24'd0, half_r} : '0;

  rtcbm_step u_step (
    .st          (st_r),
    .item        (s1_item_r),
    .half_period (half_r),
    .st_nxt      (st_nxt),
    .res         (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= rtcbm_pkg::HALF_PERIOD_RESET;
    end else if (cfg_write && reg_hit) begin
      half_r <= pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        st_r <= st_nxt;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= '{start_req:   in_start_req,
                     is_read:     in_is_read,
                     reg_command: in_reg_command,
                     write_value: in_write_value,
                     bcd:         in_bcd,
                     io_pin:      in_io_pin};
    end
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_chip_enable  = out_res_r.chip_enable;
  assign out_serial_clock = out_res_r.serial_clock;
  assign out_data_out     = out_res_r.data_out;
  assign out_data_drive   = out_res_r.data_drive;
  assign out_busy_res     = out_res_r.busy_res;
  assign out_done_res     = out_res_r.done_res;
  assign out_read_value   = out_res_r.read_value;

  a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase <= rtcbm_pkg::PH_RECV_HIGH)
    else $error("transfer phase left its legal range");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.done_res |-> !out_res_r.busy_res && !out_res_r.chip_enable)
    else $error("done reported while transfer still active");

  a_release_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_res_r.data_drive |-> !out_res_r.data_out && out_res_r.chip_enable)
    else $error("data line released outside a read or with a driven level");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_item_r) && $stable(st_r))
    else $error("input register or state changed while output stalled");

  a_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    $past(advance) && $past(st_r.phase) == rtcbm_pkg::PH_IDLE && st_r.phase != rtcbm_pkg::PH_IDLE
    |-> st_r.phase == rtcbm_pkg::PH_SEND_LOW && st_r.hold_count == 8'd0)
    else $error("transfer did not begin in the first clock-low phase");

endmodule
